### sv/prpd_pkg.sv
// ----------------------------------------------------------------------------
// prpd_pkg
// Shared types, constants and helpers for the pixel run pattern detector.
// ----------------------------------------------------------------------------
package prpd_pkg;

  // Row length limit; lengths saturate here, positions one below.
  localparam int unsigned ROW_LEN = 1024;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned POS_W = 10;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned NUM_KINDS = 5;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(ROW_LEN - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ROW_LEN);

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_GRAY = 8'd128;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BLACK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRAY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WHITE = 2'd3;

  typedef logic [NUM_KINDS-1:0][KIND_W-1:0] prpd_kinds_t;

  // Entry 0 is the oldest kind, entry 4 the newest.
  localparam prpd_kinds_t KIND_PATTERN =
    {KIND_BLACK, KIND_WHITE, KIND_GRAY, KIND_WHITE, KIND_BLACK};

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             end_of_row;
  } prpd_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  run_index;
    logic [KIND_W-1:0] run_kind;
    logic [LEN_W-1:0]  run_length;
    logic [POS_W-1:0]  midpoint;
    logic              pattern_found;
    logic              last;
  } prpd_out_t;

  // State of the open run as seen by the run closing logic.
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [LEN_W-1:0] length;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] runs_done;
    prpd_kinds_t      kinds;
  } prpd_run_t;

  function automatic logic [KIND_W-1:0] kind_of(input logic [PIX_W-1:0] v);
    logic [KIND_W-1:0] k;
    case (v)
      PIX_BLACK: k = KIND_BLACK;
      PIX_GRAY:  k = KIND_GRAY;
      PIX_WHITE: k = KIND_WHITE;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

### sv/prpd_close.sv
// ----------------------------------------------------------------------------
// prpd_close
// Builds the result for a closing run and the bookkeeping that follows it.
// ----------------------------------------------------------------------------
module prpd_close
  import prpd_pkg::*;
(
  input  prpd_run_t        run_i,
  input  logic             last_i,
  output prpd_out_t        res_o,
  output prpd_kinds_t      kinds_o,
  output logic [POS_W-1:0] runs_done_o
);

  logic [KIND_W-1:0] kind;
  logic [POS_W+1:0]  mid_sum;

  assign kind = kind_of(run_i.value);

  // Shift the new kind in at the newest end.
  assign kinds_o = {kind, run_i.kinds[NUM_KINDS-1:1]};

  assign mid_sum = (POS_W+2)'(run_i.start) + (POS_W+2)'(run_i.length >> 1);

  assign runs_done_o = (run_i.runs_done == POS_MAX) ? POS_MAX
                                                    : run_i.runs_done + 1'b1;

  always_comb begin
    res_o.run_index     = run_i.runs_done;
    res_o.run_kind      = kind;
    res_o.run_length    = run_i.length;
    res_o.midpoint      = (mid_sum > (POS_W+2)'(POS_MAX)) ? POS_MAX
                                                         : mid_sum[POS_W-1:0];
    res_o.pattern_found = (kinds_o == KIND_PATTERN);
    res_o.last          = last_i;
  end

endmodule

### sv/prpd_res_queue.sv
// ----------------------------------------------------------------------------
// prpd_res_queue
// Four-entry result queue that takes up to two results per cycle.
// ----------------------------------------------------------------------------
module prpd_res_queue
  import prpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push0_i,
  input  prpd_out_t data0_i,
  input  logic      push1_i,
  input  prpd_out_t data1_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output prpd_out_t out_data_o
);

  prpd_out_t  mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  // Two free entries are needed since one transaction can close two runs.
  assign room_o      = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_d  = wr_q + 2'(push0_i) + 2'(push1_i);
    rd_d  = rd_q + 2'(pop);
    cnt_d = cnt_q + 3'(push0_i) + 3'(push1_i) - 3'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_q + 2'd1] <= data1_i;
    end
  end

endmodule

### sv/pixel_run_pattern_detector.sv
// ----------------------------------------------------------------------------
// pixel_run_pattern_detector
// Splits a pixel row into runs of equal value and reports each closed run
// with its kind, length and midpoint, flagging the 1,3,2,3,1 kind pattern.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                             | Transaction
//   --------+-------------------------------------+---------------------------
//   in      | in_valid_i, in_stall_o, in_data_i   | one pixel of the row
//   out     | out_valid_o, out_stall_i, out_data_o| one closed run
//
// One pixel is taken per cycle unless the input stalls. Run state updates in
// the cycle a pixel is accepted; its results enter a four-entry result queue
// that hands them out one per cycle unless the output stalls. A pixel that
// both changes value and ends the row yields two results, so the input stalls
// while the queue has fewer than two free entries. Reset clears the run state
// and the queue.
module pixel_run_pattern_detector
  import prpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  prpd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output prpd_out_t out_data_o
);

  prpd_run_t        run_q, run_d;
  logic             open_q, open_d;
  prpd_run_t        run_mid;
  prpd_out_t        res_a, res_b;
  prpd_kinds_t      kinds_a, kinds_b;
  logic [POS_W-1:0] runs_a, runs_b;
  logic             room, accept, close_a;
  logic [POS_W:0]   next_start;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;
  assign close_a    = open_q && (in_data_i.pixel != run_q.value);

  prpd_close u_close_a (
    .run_i       (run_q),
    .last_i      (1'b0),
    .res_o       (res_a),
    .kinds_o     (kinds_a),
    .runs_done_o (runs_a)
  );

  assign next_start = (POS_W+1)'(run_q.start) + (POS_W+1)'(run_q.length);

  // State after the pixel joins or opens a run, before any row end.
  always_comb begin
    run_mid = run_q;
    if (close_a) begin
      run_mid.runs_done = runs_a;
      run_mid.kinds     = kinds_a;
      run_mid.start     = (next_start > (POS_W+1)'(POS_MAX)) ? POS_MAX
                                                             : next_start[POS_W-1:0];
    end
    if (close_a || !open_q) begin
      if (run_mid.runs_done == '0) begin
        run_mid.start = '0;
      end
      run_mid.value  = in_data_i.pixel;
      run_mid.length = LEN_W'(1);
    end else if (run_q.length < LEN_MAX) begin
      run_mid.length = run_q.length + 1'b1;
    end
  end

  prpd_close u_close_b (
    .run_i       (run_mid),
    .last_i      (1'b1),
    .res_o       (res_b),
    .kinds_o     (kinds_b),
    .runs_done_o (runs_b)
  );

  always_comb begin
    run_d  = run_q;
    open_d = open_q;
    if (accept) begin
      if (in_data_i.end_of_row) begin
        run_d  = '0;
        open_d = 1'b0;
      end else begin
        run_d  = run_mid;
        open_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      open_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      open_q <= open_d;
    end
  end

  // The row-end result only travels in the second slot when a value change
  // also closed a run; its bookkeeping outputs are not needed after reset.
  prpd_res_queue u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (accept && (close_a || in_data_i.end_of_row)),
    .data0_i     (close_a ? res_a : res_b),
    .push1_i     (accept && close_a && in_data_i.end_of_row
                  && (kinds_b == kinds_b) && (runs_b == runs_b)),
    .data1_i     (res_b),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### dv/prpd_run_checker.sv
// ----------------------------------------------------------------------------
// prpd_run_checker
// Watches both channels of the pixel run pattern detector. It predicts the
// closed runs of every accepted pixel and compares each run transaction, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prpd_run_checker
  import prpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  prpd_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  prpd_out_t   out_data_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned runs_checked_o,
  output int unsigned pattern_hits_o
);

  // Kinds of the five most recent runs, oldest first, that raise the flag.
  localparam logic [KIND_W-1:0] ROW_MOTIF [NUM_KINDS] =
    '{KIND_BLACK, KIND_WHITE, KIND_GRAY, KIND_WHITE, KIND_BLACK};

  logic [PIX_W-1:0]  run_value;
  bit                run_open;
  int unsigned       run_len;
  int unsigned       run_start;
  int unsigned       runs_done;
  logic [KIND_W-1:0] recent_kinds [NUM_KINDS];

  prpd_out_t   expected_runs [$];
  int unsigned errors;
  int unsigned checked;
  int unsigned hits;

  function automatic int unsigned clamp_pos(input int unsigned v);
    return (v > ROW_LEN - 1) ? ROW_LEN - 1 : v;
  endfunction

  function automatic logic [KIND_W-1:0] pixel_kind(input logic [PIX_W-1:0] v);
    if (v == PIX_BLACK) return KIND_BLACK;
    if (v == PIX_GRAY) return KIND_GRAY;
    if (v == PIX_WHITE) return KIND_WHITE;
    return KIND_OTHER;
  endfunction

  task automatic clear_row_state();
    run_value = '0;
    run_open = 0;
    run_len = 0;
    run_start = 0;
    runs_done = 0;
    for (int i = 0; i < NUM_KINDS; i++) recent_kinds[i] = KIND_OTHER;
  endtask

  task automatic close_open_run(input bit ends_row);
    logic [KIND_W-1:0] k;
    bit                hit;
    prpd_out_t         r;
    k = pixel_kind(run_value);
    for (int i = 0; i < NUM_KINDS - 1; i++) recent_kinds[i] = recent_kinds[i+1];
    recent_kinds[NUM_KINDS-1] = k;
    hit = 1;
    for (int i = 0; i < NUM_KINDS; i++) begin
      if (recent_kinds[i] != ROW_MOTIF[i]) hit = 0;
    end
    r.run_index = POS_W'(runs_done);
    r.run_kind = k;
    r.run_length = LEN_W'(run_len);
    r.midpoint = POS_W'(clamp_pos(run_start + run_len / 2));
    r.pattern_found = hit;
    r.last = ends_row;
    expected_runs.push_back(r);
    runs_done = clamp_pos(runs_done + 1);
  endtask

  task automatic predict_pixel(input prpd_in_t d);
    if (run_open && d.pixel != run_value) begin
      close_open_run(1'b0);
      run_start = clamp_pos(run_start + run_len);
      run_len = 0;
      run_open = 0;
    end
    if (run_open) begin
      if (run_len < ROW_LEN) run_len++;
    end else begin
      if (runs_done == 0) run_start = 0;
      run_value = d.pixel;
      run_len = 1;
      run_open = 1;
    end
    // The end-of-row pixel closes the open run and starts a fresh row.
    if (d.end_of_row) begin
      close_open_run(1'b1);
      clear_row_state();
    end
  endtask

  task automatic check_field(input string fname, input logic [LEN_W-1:0] want,
                             input logic [LEN_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: run field %s mismatch: expected %0d, actual %0d",
               $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    prpd_out_t want;
    if (!rst_ni) begin
      clear_row_state();
      expected_runs.delete();
      errors = 0;
      checked = 0;
      hits = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_runs.size() == 0) begin
          $display("%0t ns: run transaction with none expected: expected none, actual %p",
                   $time, out_data_i);
          errors++;
        end else begin
          want = expected_runs.pop_front();
          check_field("run_index", LEN_W'(want.run_index), LEN_W'(out_data_i.run_index));
          check_field("run_kind", LEN_W'(want.run_kind), LEN_W'(out_data_i.run_kind));
          check_field("run_length", want.run_length, out_data_i.run_length);
          check_field("midpoint", LEN_W'(want.midpoint), LEN_W'(out_data_i.midpoint));
          check_field("pattern_found", LEN_W'(want.pattern_found),
                      LEN_W'(out_data_i.pattern_found));
          check_field("last", LEN_W'(want.last), LEN_W'(out_data_i.last));
          checked++;
          if (want.pattern_found) hits++;
        end
      end
      if (in_valid_i && !in_stall_i) predict_pixel(in_data_i);
    end
    error_count_o <= errors;
    pending_o <= expected_runs.size();
    runs_checked_o <= checked;
    pattern_hits_o <= hits;
  end

endmodule

### dv/pixel_run_pattern_detector_test.sv
// ----------------------------------------------------------------------------
// pixel_run_pattern_detector_test
// Feeds rows of pixels to the run pattern detector: a few directed rows, then
// random rows rich in the 1,3,2,3,1 kind motif and one very long row, under
// four idling phases. The checker predicts and compares every run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_run_pattern_detector_test;
  import prpd_pkg::*;

  localparam int unsigned PIXELS_PER_PHASE = 200;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  prpd_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  prpd_out_t out_data_o;

  int unsigned error_count;
  int unsigned pending;
  int unsigned runs_checked;
  int unsigned pattern_hits;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned pixels_sent = 0;
  int unsigned rows_sent = 0;
  logic [PIX_W-1:0] row_pixels [$];

  pixel_run_pattern_detector uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  prpd_run_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .error_count_o (error_count),
    .pending_o     (pending),
    .runs_checked_o(runs_checked),
    .pattern_hits_o(pattern_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d runs still expected.", pending);
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic eor);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{pixel: px, end_of_row: eor};
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
  endtask

  task automatic send_row();
    foreach (row_pixels[i]) send_pixel(row_pixels[i], i == row_pixels.size() - 1);
    rows_sent++;
  endtask

  task automatic append_run(input logic [PIX_W-1:0] v, input int unsigned n);
    repeat (n) row_pixels.push_back(v);
  endtask

  // Mostly the three special values, so that kind sequences line up often.
  function automatic logic [PIX_W-1:0] random_value();
    case ($urandom_range(9))
      0, 1:    return PIX_BLACK;
      2, 3:    return PIX_GRAY;
      4, 5:    return PIX_WHITE;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned random_len();
    return ($urandom_range(7) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
  endfunction

  // Random runs with the motif placed somewhere in most rows, sometimes with
  // one of its values spoiled.
  task automatic build_random_row();
    int unsigned n_runs;
    int unsigned motif_at;
    int unsigned mode;
    int unsigned spoiled;
    logic [PIX_W-1:0] motif [5];
    row_pixels.delete();
    n_runs = $urandom_range(1, 12);
    mode = $urandom_range(3);
    motif_at = $urandom_range(n_runs);
    spoiled = (mode == 2) ? $urandom_range(4) : 5;
    motif = '{PIX_BLACK, PIX_WHITE, PIX_GRAY, PIX_WHITE, PIX_BLACK};
    for (int r = 0; r <= n_runs; r++) begin
      if (r == motif_at && mode != 3) begin
        for (int j = 0; j < 5; j++) begin
          append_run((j == spoiled) ? random_value() : motif[j], $urandom_range(1, 3));
        end
      end
      if (r < n_runs) append_run(random_value(), random_len());
    end
  endtask

  // One uniform run past the length limit, then a short tail of alternating
  // pixels whose runs start at the saturated position.
  task automatic build_long_row();
    logic [PIX_W-1:0] a;
    int unsigned      n_alt;
    row_pixels.delete();
    a = PIX_W'($urandom_range(255));
    append_run(a, $urandom_range(1025, 1060));
    n_alt = $urandom_range(16, 24);
    for (int i = 0; i < n_alt; i++) row_pixels.push_back(i[0] ? a ^ 8'hAA : a ^ 8'h55);
  endtask

  initial begin
    int unsigned phase_idle [4];
    int unsigned phase_stall [4];
    int unsigned phase_start;
    phase_idle = '{0, 51, 0, 9};
    phase_stall = '{0, 0, 51, 9};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows.
    row_pixels = '{8'd0};
    send_row();
    row_pixels = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0};
    send_row();
    row_pixels = '{8'd128, 8'd128};
    send_row();
    row_pixels = '{8'd1, 8'd254, 8'd127, 8'd129, 8'd200, 8'd200, 8'd200};
    send_row();
    row_pixels = '{8'd255, 8'd0, 8'd128};
    send_row();
    row_pixels = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd77};
    send_row();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 0) begin
        build_long_row();
        send_row();
      end
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < PIXELS_PER_PHASE) begin
        build_random_row();
        send_row();
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d pixels in %0d rows, one past the length limit, over four idling phases.",
             pixels_sent, rows_sent);
    $display("Checked %0d runs, %0d of them flagging the kind pattern.",
             runs_checked, pattern_hits);
    if (error_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
sv/prpd_pkg.sv
sv/prpd_close.sv
sv/prpd_res_queue.sv
sv/pixel_run_pattern_detector.sv
dv/prpd_run_checker.sv
dv/pixel_run_pattern_detector_test.sv
